@@ src/vn_pkg.sv @@
// Shared types and widths for the four-component vector normalizer.
// Used by every module under src; depends on nothing.
package vn_pkg;

    localparam int COMP_W    = 32;
    localparam int SUM_W     = 65;
    localparam int ROOT_W    = 33;
    localparam int SQRT_REM_W = 36;
    localparam int QUO_W     = 31;
    localparam int DIV_REM_W = 34;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
        logic signed [COMP_W-1:0] in_w;
    } vec_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic signed [COMP_W-1:0] unit_w;
        logic [ROOT_W-1:0]        length;
        logic                     zero_vector;
    } vec_out_t;

    // component magnitudes and signs, lane 0 is x
    typedef struct packed {
        logic [3:0][COMP_W-1:0] mag;
        logic [3:0]             neg;
    } vn_side_t;

endpackage

@@ src/vn_square_sum.sv @@
// Magnitude, squaring and sum-of-squares stages (four register stages).
// Depends on vn_pkg.
module vn_square_sum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  vn_pkg::vec_in_t             vec,
    output logic                        valid_out,
    output logic [vn_pkg::SUM_W-1:0]    sum,
    output vn_pkg::vn_side_t            side
);

    logic [3:0]                           valid_reg;
    vn_pkg::vn_side_t                     side1_reg, side2_reg, side3_reg, side4_reg;
    logic [3:0][2*vn_pkg::COMP_W-1:0]     sq_reg;
    logic [1:0][vn_pkg::SUM_W-1:0]        pair_reg;
    logic [vn_pkg::SUM_W-1:0]             sum_reg;
    logic [3:0][vn_pkg::COMP_W-1:0]       raw;
    vn_pkg::vn_side_t                     side1_next;

    assign raw[0] = vec.in_x;
    assign raw[1] = vec.in_y;
    assign raw[2] = vec.in_z;
    assign raw[3] = vec.in_w;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            side1_next.neg[i] = raw[i][vn_pkg::COMP_W-1];
            side1_next.mag[i] = raw[i][vn_pkg::COMP_W-1] ? (~raw[i] + 1'b1) : raw[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= side1_reg.mag[i] * side1_reg.mag[i];
            end
            side2_reg   <= side1_reg;
            pair_reg[0] <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
            pair_reg[1] <= {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
            side3_reg   <= side2_reg;
            sum_reg     <= pair_reg[0] + pair_reg[1];
            side4_reg   <= side3_reg;
        end
    end

    assign valid_out = valid_reg[3];
    assign sum       = sum_reg;
    assign side      = side4_reg;

endmodule

@@ src/vn_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Depends on vn_pkg.
module vn_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [vn_pkg::SUM_W-1:0]    sum,
    input  vn_pkg::vn_side_t            side_in,
    output logic                        valid_out,
    output logic [vn_pkg::ROOT_W-1:0]   root,
    output vn_pkg::vn_side_t            side_out
);

    localparam int NST = vn_pkg::ROOT_W;
    localparam int S_W = 2 * vn_pkg::ROOT_W;

    logic [NST:0]                        valid_reg;
    logic [NST:0][S_W-1:0]               s_reg;
    logic [NST:0][vn_pkg::SQRT_REM_W-1:0] rem_reg;
    logic [NST:0][vn_pkg::ROOT_W-1:0]    root_reg;
    vn_pkg::vn_side_t                    side_reg [NST+1];

    assign valid_reg[0] = valid_in;
    assign s_reg[0]     = {{(S_W-vn_pkg::SUM_W){1'b0}}, sum};
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;
    assign side_reg[0]  = side_in;

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        localparam int J = NST - 1 - g;
        logic [vn_pkg::SQRT_REM_W-1:0] rem_sh, trial;
        logic                          ge;

        always_comb
        begin
            rem_sh = {rem_reg[g][vn_pkg::SQRT_REM_W-3:0], s_reg[g][2*J+1 -: 2]};
            trial  = {{(vn_pkg::SQRT_REM_W-vn_pkg::ROOT_W-2){1'b0}}, root_reg[g], 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[g+1]    <= s_reg[g];
                rem_reg[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[g+1] <= {root_reg[g][vn_pkg::ROOT_W-2:0], ge};
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign valid_out = valid_reg[NST];
    assign root      = root_reg[NST];
    assign side_out  = side_reg[NST];

endmodule

@@ src/vn_divide.sv @@
// One lane of the pipelined restoring divider: magnitude / length in Q1.30,
// one quotient bit per stage, then sign and zero-length fixup. Depends on vn_pkg.
module vn_divide (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid_in,
    input  logic [vn_pkg::COMP_W-1:0]         mag,
    input  logic                              neg,
    input  logic [vn_pkg::ROOT_W-1:0]         len_in,
    output logic                              valid_out,
    output logic signed [vn_pkg::COMP_W-1:0]  unit,
    output logic [vn_pkg::ROOT_W-1:0]         len_out
);

    localparam int NST = vn_pkg::QUO_W;

    logic [NST:0]                          valid_reg;
    logic [NST:0][vn_pkg::DIV_REM_W-1:0]   rem_reg;
    logic [NST:0][vn_pkg::QUO_W-1:0]       q_reg;
    logic [NST:0][vn_pkg::ROOT_W-1:0]      len_reg;
    logic [NST:0]                          neg_reg;
    logic                                  out_valid_reg;
    logic signed [vn_pkg::COMP_W-1:0]      unit_reg;
    logic [vn_pkg::ROOT_W-1:0]             out_len_reg;
    logic [vn_pkg::COMP_W-1:0]             q_ext;

    assign valid_reg[0] = valid_in;
    assign rem_reg[0]   = {{(vn_pkg::DIV_REM_W-vn_pkg::COMP_W){1'b0}}, mag};
    assign q_reg[0]     = '0;
    assign len_reg[0]   = len_in;
    assign neg_reg[0]   = neg;

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        logic [vn_pkg::DIV_REM_W-1:0] dvs, rem_sel;
        logic                         ge;

        always_comb
        begin
            dvs     = {{(vn_pkg::DIV_REM_W-vn_pkg::ROOT_W){1'b0}}, len_reg[g]};
            ge      = rem_reg[g] >= dvs;
            rem_sel = ge ? (rem_reg[g] - dvs) : rem_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1] <= {rem_sel[vn_pkg::DIV_REM_W-2:0], 1'b0};
                q_reg[g+1]   <= {q_reg[g][vn_pkg::QUO_W-2:0], ge};
                len_reg[g+1] <= len_reg[g];
                neg_reg[g+1] <= neg_reg[g];
            end
        end
    end

    assign q_ext = {{(vn_pkg::COMP_W-vn_pkg::QUO_W){1'b0}}, q_reg[NST]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_len_reg <= len_reg[NST];
            if (len_reg[NST] == '0)
            begin
                unit_reg <= '0;
            end
            else
            begin
                unit_reg <= neg_reg[NST] ? (~q_ext + 1'b1) : q_ext;
            end
        end
    end

    assign valid_out = out_valid_reg;
    assign unit      = unit_reg;
    assign len_out   = out_len_reg;

endmodule

@@ src/vec4_normalize_core.sv @@
// Top level of the four-component vector normalizer.
// Depends on vn_pkg, vn_square_sum, vn_isqrt, vn_divide.
//
//  channel | signals                        | payload
//  --------+--------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data    | vec_in_t: in_x..in_w, Q15.16
//  output  | out_valid, out_ready, out_data | vec_out_t: unit_*, length, flag
//
// One item per cycle unless the output stalls; the stages run square/sum, then root, then divide.
// Each root bit and each quotient bit has a stage of its own.
// Reset clears the valid bits only. When a result waits at the output and
// out_ready is low, the whole pipeline holds and in_ready drops.
module vec4_normalize_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vn_pkg::vec_in_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vn_pkg::vec_out_t  out_data
);

    logic                              en;
    logic                              sq_valid, rt_valid;
    logic [vn_pkg::SUM_W-1:0]          sum;
    vn_pkg::vn_side_t                  sq_side, rt_side;
    logic [vn_pkg::ROOT_W-1:0]         root;
    logic [3:0]                        lane_valid;
    logic [3:0][vn_pkg::COMP_W-1:0]    lane_unit;
    logic [3:0][vn_pkg::ROOT_W-1:0]    lane_len;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    vn_square_sum u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .vec       (in_data),
        .valid_out (sq_valid),
        .sum       (sum),
        .side      (sq_side)
    );

    vn_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sq_valid),
        .sum       (sum),
        .side_in   (sq_side),
        .valid_out (rt_valid),
        .root      (root),
        .side_out  (rt_side)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        vn_divide u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (rt_valid),
            .mag       (rt_side.mag[i]),
            .neg       (rt_side.neg[i]),
            .len_in    (root),
            .valid_out (lane_valid[i]),
            .unit      (lane_unit[i]),
            .len_out   (lane_len[i])
        );
    end

    // all lanes run in lockstep; lane x supplies valid and length
    assign out_valid            = lane_valid[0];
    assign out_data.unit_x      = lane_unit[0];
    assign out_data.unit_y      = lane_unit[1];
    assign out_data.unit_z      = lane_unit[2];
    assign out_data.unit_w      = lane_unit[3];
    assign out_data.length      = lane_len[0];
    assign out_data.zero_vector = (lane_len[0] == '0);

endmodule

@@ test/testbench.sv @@
// Testbench for vec4_normalize_core: streams vectors through the normalizer and
// checks every result against a built-in bit-exact predictor. Depends on vn_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 69;
    localparam int MAX_CYCLE = 1500000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    vn_pkg::vec_in_t  in_data;
    logic             out_valid;
    logic             out_ready;
    vn_pkg::vec_out_t out_data;

    vn_pkg::vec_out_t norm_expected[$];
    int               mismatch_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_cycles;
    longint           cycle_count;

    vec4_normalize_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic vn_pkg::vec_out_t normalize(vn_pkg::vec_in_t v);
        logic [3:0][31:0] comp;
        logic [3:0][31:0] mag;
        logic [3:0]       neg;
        logic [64:0]      sum;
        logic [32:0]      root;
        logic [32:0]      trial;
        logic [65:0]      sq;
        logic [62:0]      q;
        logic [3:0][31:0] unit;
        vn_pkg::vec_out_t r;
        comp = {v.in_x, v.in_y, v.in_z, v.in_w};
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = comp[i][31];
            mag[i] = neg[i] ? 32'(-comp[i]) : comp[i];
            sum += 65'(64'(mag[i]) * 64'(mag[i]));
        end
        root = '0;
        for (int b = 32; b >= 0; b--)
        begin
            trial = root | (33'd1 << b);
            sq = 66'(trial) * 66'(trial);
            if (sq <= 66'(sum))
                root = trial;
        end
        for (int i = 0; i < 4; i++)
        begin
            unit[i] = '0;
            if (root != 0)
            begin
                q = 63'((63'(mag[i]) << 30) / 63'(root));
                unit[i] = neg[i] ? 32'(-q[31:0]) : q[31:0];
            end
        end
        r.unit_x = unit[3];
        r.unit_y = unit[2];
        r.unit_z = unit[1];
        r.unit_w = unit[0];
        r.length = root;
        r.zero_vector = (root == 0);
        return r;
    endfunction

    // valid drops only while the sender idles, so back-to-back items keep it high
    task automatic send_vector(vn_pkg::vec_in_t v);
        while (($urandom_range(99) < send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        norm_expected.push_back(normalize(v));
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off when hold_cycles is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        vn_pkg::vec_out_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (norm_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    exp_r = norm_expected.pop_front();
                    if (out_data.unit_x !== exp_r.unit_x ||
                        out_data.unit_y !== exp_r.unit_y ||
                        out_data.unit_z !== exp_r.unit_z ||
                        out_data.unit_w !== exp_r.unit_w ||
                        out_data.length !== exp_r.length ||
                        out_data.zero_vector !== exp_r.zero_vector)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h got %h", exp_r, out_data);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(512)) - 256);
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                32'd1, 32'h0001_0000, 32'hFFFF_0000};
        send_vector('0);                                   // zero vector
        send_vector({4{32'h8000_0000}});                   // sum is exactly 2^64
        send_vector({4{32'h7FFF_FFFF}});
        for (int i = 0; i < 6; i++)
        begin
            // one nonzero component, rotating lanes
            send_vector(vn_pkg::vec_in_t'(128'(ext[i]) << (32 * (i % 4))));
        end
        send_vector({32'd3, 32'd4, 32'd0, 32'd0});
        send_vector({32'hFFFF_FFFD, 32'd4, 32'hFFFF_FFF4, 32'd0});
        send_vector({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_vector({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
        send_vector({32'd1, 32'd1, 32'd1, 32'd1});
        send_vector({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                send_vector({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
            else
                send_vector({$urandom, $urandom, $urandom, $urandom});
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 200;
        test_random(150);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_count = 0;
        hold_cycles = 0;
        send_idle_pct = 30;
        recv_idle_pct = 75;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(600);
        send_idle_pct = 75;
        recv_idle_pct = 30;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(580);
        test_backpressure();
        in_valid <= 1'b0;

        waited = 0;
        while (norm_expected.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && norm_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
src/vn_pkg.sv
src/vn_square_sum.sv
src/vn_isqrt.sv
src/vn_divide.sv
src/vec4_normalize_core.sv
test/testbench.sv
